// ===== rtl/wpwr_pkg.sv =====
// Package for the weighted pick block: sizes, codes, FSM states and the cell
// control bundle. No dependencies.
`default_nettype none
package wpwr_pkg;

  localparam int MAX_ITEMS    = 64;
  localparam int MAX_REPLICAS = 16;
  localparam int ID_W         = 32;
  localparam int WT_W         = 32;
  localparam int SEED_W       = 64;
  localparam int REP_W        = 5;
  localparam int CUM_W        = WT_W + $clog2(MAX_ITEMS);
  localparam int CNT_W        = $clog2(MAX_ITEMS + 1);
  localparam int HALF_W       = SEED_W / 2;

  localparam logic [HALF_W-1:0] HOP = 32'd2654435761;

  // stream payload widths, padded to whole bytes
  localparam int IN_DATA_W  = ((ID_W + WT_W + SEED_W + REP_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((ID_W + 2 + 7) / 8) * 8;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_WT    = 2'd1,
    ST_TOO_FEW  = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_LO,
    S_MUL_HI,
    S_MOD,
    S_MOD_WAIT,
    S_SEARCH,
    S_EMIT,
    S_SHIFT,
    S_STRIDE_WAIT,
    S_FINAL
  } state_e;

  // shared control broadcast to every cell
  typedef struct packed {
    logic             shift;
    logic [CUM_W-1:0] pos;
    logic [CUM_W-1:0] w;
    logic [ID_W-1:0]  load_id;
    logic [CUM_W-1:0] load_cum;
  } cell_ctrl_t;

endpackage
`default_nettype wire

// ===== rtl/wpwr_cell.sv =====
// One table cell: holds a candidate id and its running weight total.
// Depends on wpwr_pkg.
`default_nettype none
module wpwr_cell (
  input  wire logic                       clk_i,
  input  wire wpwr_pkg::cell_ctrl_t       ctrl_i,
  input  wire logic                       load_en_i,
  input  wire logic                       valid_i,
  input  wire logic [wpwr_pkg::ID_W-1:0]  nb_id_i,
  input  wire logic [wpwr_pkg::CUM_W-1:0] nb_cum_i,
  input  wire logic [wpwr_pkg::CUM_W-1:0] prev_cum_i,
  output logic                            hit_o,
  output logic [wpwr_pkg::ID_W-1:0]       id_o,
  output logic [wpwr_pkg::CUM_W-1:0]      cum_o,
  output logic [wpwr_pkg::CUM_W-1:0]      weight_o
);

  logic [wpwr_pkg::ID_W-1:0]  id_q;
  logic [wpwr_pkg::CUM_W-1:0] cum_q;

  // totals rise strictly, so every valid cell at or past the chosen one hits
  assign hit_o    = valid_i && (cum_q > ctrl_i.pos);
  assign id_o     = id_q;
  assign cum_o    = cum_q;
  assign weight_o = cum_q - prev_cum_i;

  // append on load, take the upper neighbor on removal
  always_ff @(posedge clk_i) begin
    if (load_en_i) begin
      id_q  <= ctrl_i.load_id;
      cum_q <= ctrl_i.load_cum;
    end else if (ctrl_i.shift && hit_o) begin
      id_q  <= nb_id_i;
      cum_q <= nb_cum_i - ctrl_i.w;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/wpwr_div.sv =====
// Restoring divider, one quotient bit per cycle, for modulo and stride.
// Depends on wpwr_pkg.
`default_nettype none
module wpwr_div (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [wpwr_pkg::SEED_W-1:0] num_i,
  input  wire logic [wpwr_pkg::CUM_W-1:0]  den_i,
  output logic                             done_o,
  output logic [wpwr_pkg::SEED_W-1:0]      quo_o,
  output logic [wpwr_pkg::CUM_W-1:0]       rem_o
);

  localparam int STEP_W = $clog2(wpwr_pkg::SEED_W);

  logic                         busy_q, busy_d, done_q, done_d;
  logic [STEP_W-1:0]            cnt_q, cnt_d;
  logic [wpwr_pkg::SEED_W-1:0]  quo_q, quo_d;
  logic [wpwr_pkg::CUM_W-1:0]   rem_q, rem_d, den_q, den_d;
  logic [wpwr_pkg::CUM_W:0]     sh, diff;

  assign sh     = {rem_q, quo_q[wpwr_pkg::SEED_W-1]};
  assign diff   = sh - {1'b0, den_q};
  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

  // one shift-subtract step per cycle
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '1;
      quo_d  = num_i;
      rem_d  = '0;
      den_d  = den_i;
    end else if (busy_q) begin
      if (!diff[wpwr_pkg::CUM_W]) begin
        rem_d = diff[wpwr_pkg::CUM_W-1:0];
        quo_d = {quo_q[wpwr_pkg::SEED_W-2:0], 1'b1};
      end else begin
        rem_d = sh[wpwr_pkg::CUM_W-1:0];
        quo_d = {quo_q[wpwr_pkg::SEED_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

endmodule
`default_nettype wire

// ===== rtl/weighted_pick_without_replacement.sv =====
// Loads: one item is taken per cycle while the sequencer is idle.
// A request forms the cursor (S_MUL_LO, S_MUL_HI), then per pick runs modulo,
// search, emit (held while the output is full), shift and stride division (one
// shared divider; the last pick skips the stride), then the final status.
// Reset: asynchronous, active low; clears table count, total, overflow, FSM, output valid.
// Depends on wpwr_pkg, wpwr_cell, wpwr_div.
`default_nettype none
module weighted_pick_without_replacement (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // item_id[31:0], weight[63:32], seed[127:64], replicas[132:128], zero pad
  input  wire logic [wpwr_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // kind
  input  wire logic                              s_axis_tuser,
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // picked_id[31:0], status[33:32], zero pad
  output logic [wpwr_pkg::OUT_DATA_W-1:0]        m_axis_tdata,
  // pick_valid
  output logic                                   m_axis_tuser,
  output logic                                   m_axis_tlast
);

  localparam int N = wpwr_pkg::MAX_ITEMS;
  localparam int CW = wpwr_pkg::CUM_W;
  localparam int SW = wpwr_pkg::SEED_W;
  localparam int HW = wpwr_pkg::HALF_W;

  // input fields
  logic [wpwr_pkg::ID_W-1:0]  in_id;
  logic [wpwr_pkg::WT_W-1:0]  in_wt;
  logic [SW-1:0]              in_seed;
  logic [wpwr_pkg::REP_W-1:0] in_reps;
  logic                       in_xfer;

  assign in_id   = s_axis_tdata[31:0];
  assign in_wt   = s_axis_tdata[63:32];
  assign in_seed = s_axis_tdata[127:64];
  assign in_reps = s_axis_tdata[132:128];
  assign in_xfer = s_axis_tvalid && s_axis_tready;

  wpwr_pkg::state_e             state_q, state_d;
  logic [wpwr_pkg::CNT_W-1:0]   cnt_q, cnt_d;
  logic [CW-1:0]                total_q, total_d;
  logic                         ovf_q, ovf_d;
  logic [wpwr_pkg::REP_W-1:0]   reps_q, reps_d, filled_q, filled_d, owed;
  wpwr_pkg::status_e            stat_q, stat_d;
  logic [SW-1:0]                cursor_q, cursor_d, lo_q, lo_d;
  logic [CW-1:0]                pos_q, pos_d, pw_q, pw_d;
  logic [wpwr_pkg::ID_W-1:0]    pid_q, pid_d;

  // output register
  logic                         ov_q, ov_d, opick_q, opick_d, olast_q, olast_d;
  logic [wpwr_pkg::ID_W-1:0]    oid_q, oid_d;
  wpwr_pkg::status_e            ost_q, ost_d;
  logic                         out_free;

  // divider hookup
  logic          div_start, div_done;
  logic [SW-1:0] div_num, div_quo;
  logic [CW-1:0] div_den, div_rem;

  // cell chain
  wpwr_pkg::cell_ctrl_t         ctrl;
  logic [N-1:0]                 hit, load_en, valid;
  logic [wpwr_pkg::ID_W-1:0]    cid [N];
  logic [CW-1:0]                ccum [N];
  logic [CW-1:0]                cwt [N];
  logic [wpwr_pkg::ID_W-1:0]    sel_id;
  logic [CW-1:0]                sel_wt;
  logic [HW-1:0]                mul_a;
  logic [SW-1:0]                mul_p;

  assign out_free = !ov_q || m_axis_tready;
  assign owed     = reps_q - filled_q;
  assign mul_a    = (state_q == wpwr_pkg::S_MUL_LO) ? lo_q[HW-1:0] : lo_q[SW-1:HW];
  assign mul_p    = mul_a * wpwr_pkg::HOP;

  always_comb begin
    ctrl.shift    = (state_q == wpwr_pkg::S_SHIFT);
    ctrl.pos      = pos_q;
    ctrl.w        = pw_q;
    ctrl.load_id  = in_id;
    ctrl.load_cum = total_q + CW'(in_wt);
  end

  for (genvar i = 0; i < N; i++) begin : g_cell
    logic [wpwr_pkg::ID_W-1:0] nb_id;
    logic [CW-1:0]             nb_cum, prev_cum;
    if (i == N - 1) begin : g_top
      assign nb_id  = '0;
      assign nb_cum = '0;
    end else begin : g_mid
      assign nb_id  = cid[i+1];
      assign nb_cum = ccum[i+1];
    end
    if (i == 0) begin : g_bot
      assign prev_cum = '0;
    end else begin : g_up
      assign prev_cum = ccum[i-1];
    end
    assign valid[i]   = (wpwr_pkg::CNT_W'(i) < cnt_q);
    assign load_en[i] = in_xfer && !s_axis_tuser && (in_wt != '0)
                        && (wpwr_pkg::CNT_W'(i) == cnt_q);
    wpwr_cell u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl),
      .load_en_i  (load_en[i]),
      .valid_i    (valid[i]),
      .nb_id_i    (nb_id),
      .nb_cum_i   (nb_cum),
      .prev_cum_i (prev_cum),
      .hit_o      (hit[i]),
      .id_o       (cid[i]),
      .cum_o      (ccum[i]),
      .weight_o   (cwt[i])
    );
  end

  // pick the first hitting cell
  always_comb begin
    sel_id = '0;
    sel_wt = '0;
    for (int i = 0; i < N; i++) begin
      if (hit[i] && (i == 0 || !hit[(i == 0) ? 0 : i-1])) begin
        sel_id = sel_id | cid[i];
        sel_wt = sel_wt | cwt[i];
      end
    end
  end

  wpwr_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo),
    .rem_o   (div_rem)
  );

  // request sequencer
  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    total_d   = total_q;
    ovf_d     = ovf_q;
    reps_d    = reps_q;
    filled_d  = filled_q;
    stat_d    = stat_q;
    cursor_d  = cursor_q;
    lo_d      = lo_q;
    pos_d     = pos_q;
    pw_d      = pw_q;
    pid_d     = pid_q;
    ov_d      = ov_q && !m_axis_tready;
    opick_d   = opick_q;
    olast_d   = olast_q;
    oid_d     = oid_q;
    ost_d     = ost_q;
    div_start = 1'b0;
    div_num   = cursor_q;
    div_den   = total_q;
    s_axis_tready = (state_q == wpwr_pkg::S_IDLE);
    unique case (state_q)
      wpwr_pkg::S_IDLE: begin
        if (in_xfer && !s_axis_tuser) begin
          if (in_wt != '0) begin
            if (cnt_q == wpwr_pkg::CNT_W'(N)) begin
              ovf_d = 1'b1;
            end else begin
              total_d = ctrl.load_cum;
              cnt_d   = cnt_q + 1'b1;
            end
          end
        end else if (in_xfer) begin
          reps_d   = (int'(in_reps) > wpwr_pkg::MAX_REPLICAS) ?
                     wpwr_pkg::REP_W'(wpwr_pkg::MAX_REPLICAS) : in_reps;
          filled_d = '0;
          lo_d     = in_seed;
          if (ovf_q) begin
            stat_d  = wpwr_pkg::ST_OVERFLOW;
            state_d = wpwr_pkg::S_FINAL;
          end else if (total_q == '0) begin
            stat_d  = wpwr_pkg::ST_NO_WT;
            state_d = wpwr_pkg::S_FINAL;
          end else begin
            stat_d  = wpwr_pkg::ST_OK;
            state_d = wpwr_pkg::S_MUL_LO;
          end
        end
      end
      wpwr_pkg::S_MUL_LO: begin
        cursor_d = mul_p;
        state_d  = wpwr_pkg::S_MUL_HI;
      end
      wpwr_pkg::S_MUL_HI: begin
        cursor_d = cursor_q + {mul_p[HW-1:0], {HW{1'b0}}};
        state_d  = (reps_q == '0) ? wpwr_pkg::S_FINAL : wpwr_pkg::S_MOD;
      end
      wpwr_pkg::S_MOD: begin
        div_start = 1'b1;
        state_d   = wpwr_pkg::S_MOD_WAIT;
      end
      wpwr_pkg::S_MOD_WAIT: begin
        if (div_done) begin
          pos_d   = div_rem;
          state_d = wpwr_pkg::S_SEARCH;
        end
      end
      wpwr_pkg::S_SEARCH: begin
        pid_d   = sel_id;
        pw_d    = sel_wt;
        state_d = wpwr_pkg::S_EMIT;
      end
      wpwr_pkg::S_EMIT: begin
        if (out_free) begin
          ov_d     = 1'b1;
          opick_d  = 1'b1;
          olast_d  = 1'b0;
          oid_d    = pid_q;
          ost_d    = wpwr_pkg::ST_OK;
          filled_d = filled_q + 1'b1;
          state_d  = wpwr_pkg::S_SHIFT;
        end
      end
      wpwr_pkg::S_SHIFT: begin
        cnt_d   = cnt_q - 1'b1;
        total_d = total_q - pw_q;
        div_num = SW'(total_d);
        div_den = CW'(owed);
        if (owed == '0 || cnt_d == '0) begin
          state_d = wpwr_pkg::S_FINAL;
        end else begin
          div_start = 1'b1;
          state_d   = wpwr_pkg::S_STRIDE_WAIT;
        end
      end
      wpwr_pkg::S_STRIDE_WAIT: begin
        if (div_done) begin
          cursor_d = cursor_q + ((div_quo == '0) ? SW'(1) : div_quo);
          state_d  = wpwr_pkg::S_MOD;
        end
      end
      wpwr_pkg::S_FINAL: begin
        if (out_free) begin
          ov_d    = 1'b1;
          opick_d = 1'b0;
          olast_d = 1'b1;
          oid_d   = '0;
          if (stat_q != wpwr_pkg::ST_OK) begin
            ost_d = stat_q;
          end else begin
            ost_d = (filled_q < reps_q) ? wpwr_pkg::ST_TOO_FEW : wpwr_pkg::ST_OK;
          end
          cnt_d   = '0;
          total_d = '0;
          ovf_d   = 1'b0;
          state_d = wpwr_pkg::S_IDLE;
        end
      end
      default: state_d = wpwr_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= wpwr_pkg::S_IDLE;
      cnt_q   <= '0;
      total_q <= '0;
      ovf_q   <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      total_q <= total_d;
      ovf_q   <= ovf_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    reps_q   <= reps_d;
    filled_q <= filled_d;
    stat_q   <= stat_d;
    cursor_q <= cursor_d;
    lo_q     <= lo_d;
    pos_q    <= pos_d;
    pw_q     <= pw_d;
    pid_q    <= pid_d;
    opick_q  <= opick_d;
    olast_q  <= olast_d;
    oid_q    <= oid_d;
    ost_q    <= ost_d;
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = {{(wpwr_pkg::OUT_DATA_W - wpwr_pkg::ID_W - 2){1'b0}}, ost_q, oid_q};
  assign m_axis_tuser  = opick_q;
  assign m_axis_tlast  = olast_q;

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= wpwr_pkg::CNT_W'(N))
    else $error("table count past capacity");

  a_cnt_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) == (total_q == '0))
    else $error("table count and weight total disagree");

  a_req_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && s_axis_tuser) |=> !s_axis_tready)
    else $error("input taken while a request is in progress");

  a_final_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tlast && !$stable(ov_q)) |-> (cnt_q == '0 && !ovf_q))
    else $error("load state not cleared with final status");
`endif

endmodule
`default_nettype wire
